### hw/rtl/tlii_pkg.sv
// ----------------------------------------------------------------------------
// tlii_pkg
// Shared types, codes and constants of the table interpolator with integral.
// ----------------------------------------------------------------------------
package tlii_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int CFG_W          = 5;
    localparam int MUL_W          = 33;
    localparam int PROD_W         = 2 * MUL_W;
    localparam int DIV_STEPS      = PROD_W;
    localparam int DIVCNT_W       = $clog2(DIV_STEPS + 1);
    localparam int ACC_W          = 56;
    localparam int INTEG_W        = 48;
    localparam int TERM_SHIFT     = 17;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_FEW    = 3'd2,
        ST_NONINC = 3'd3,
        ST_SAT    = 3'd4
    } status_t;

    typedef struct packed {
        logic               op;
        logic [3:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_z;
    } tlii_in_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic signed [47:0] integral_value;
        logic [2:0]         status;
    } tlii_out_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_ACCEPT,
        DP_RD_FIRST,
        DP_RD_LAST,
        DP_RANGE,
        DP_BIS_RD,
        DP_BIS_UPD,
        DP_SEG_RD0,
        DP_SEG_RD1,
        DP_SEG_LAT,
        DP_SLOPE_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_INTERP,
        DP_IG_RD0,
        DP_IG_FIRST,
        DP_IG_RD,
        DP_IG_MUL,
        DP_IG_ACC,
        DP_PART_MUL,
        DP_PART_ACC,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t code;
        logic    keep;
    } dp_cmd_t;

    typedef struct packed {
        logic n_small;
        logic out_range;
        logic bis_done;
        logic bad_x;
        logic div_last;
        logic k_more;
        logic out_free;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_RANGE,
        S_BIS,
        S_BIS_UPD,
        S_SEG_RD0,
        S_SEG_RD1,
        S_SEG_LAT,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_INTERP,
        S_IG_RD0,
        S_IG_FIRST,
        S_IG_RD,
        S_IG_MUL,
        S_IG_ACC,
        S_PART_MUL,
        S_PART_ACC,
        S_FIN
    } ctrl_state_t;

endpackage

### hw/rtl/table_linear_interp_integ_top.sv
// A load word and a query with too few points go straight to the result; an out-of-range
// query stops after the range check; otherwise the time grows with the bisection depth
// over n points in use and with the interval i found, since the trapezoid sweep reads
// the one-read-port point store segment by segment after a restoring slope division.
// One word is in work at a time; reset is synchronous active low, points_in_use = 2.
// ----------------------------------------------------------------------------
// table_linear_interp_integ_top
// Piecewise-linear table interpolator with saturating trapezoid integral.
// ----------------------------------------------------------------------------
module table_linear_interp_integ_top
    import tlii_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tlii_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tlii_out_t        m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tlii_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tlii_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

### hw/rtl/tlii_ram.sv
// ----------------------------------------------------------------------------
// tlii_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlii_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tlii_ctrl.sv
// ----------------------------------------------------------------------------
// tlii_ctrl
// Sequencer: steps the datapath through range check, bisection, slope
// division, trapezoid sweep and result hand-off.
// ----------------------------------------------------------------------------
module tlii_ctrl
    import tlii_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_op,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    status_t     code_reg, code_next;
    logic        keep_reg, keep_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
            keep_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
            keep_reg  <= keep_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        keep_next  = keep_reg;
        s_ready    = 1'b0;
        cmd.op     = DP_NONE;
        cmd.code   = code_reg;
        cmd.keep   = keep_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op    = DP_ACCEPT;
                    keep_next = 1'b0;
                    if (s_op == OP_LOAD) begin
                        code_next  = ST_OK;
                        state_next = S_FIN;
                    end else if (stat.n_small) begin
                        code_next  = ST_FEW;
                        state_next = S_FIN;
                    end else begin
                        state_next = S_RD_FIRST;
                    end
                end
            end
            S_RD_FIRST: begin
                cmd.op     = DP_RD_FIRST;
                state_next = S_RD_LAST;
            end
            S_RD_LAST: begin
                cmd.op     = DP_RD_LAST;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                cmd.op = DP_RANGE;
                if (stat.out_range) begin
                    code_next  = ST_RANGE;
                    state_next = S_FIN;
                end else begin
                    state_next = S_BIS;
                end
            end
            S_BIS: begin
                if (stat.bis_done) begin
                    state_next = S_SEG_RD0;
                end else begin
                    cmd.op     = DP_BIS_RD;
                    state_next = S_BIS_UPD;
                end
            end
            S_BIS_UPD: begin
                cmd.op     = DP_BIS_UPD;
                state_next = S_BIS;
            end
            S_SEG_RD0: begin
                cmd.op     = DP_SEG_RD0;
                state_next = S_SEG_RD1;
            end
            S_SEG_RD1: begin
                cmd.op     = DP_SEG_RD1;
                state_next = S_SEG_LAT;
            end
            S_SEG_LAT: begin
                cmd.op = DP_SEG_LAT;
                if (stat.bad_x) begin
                    code_next  = ST_NONINC;
                    state_next = S_FIN;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.op     = DP_SLOPE_MUL;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.op     = DP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = DP_DIV_STEP;
                if (stat.div_last) begin
                    state_next = S_INTERP;
                end
            end
            S_INTERP: begin
                cmd.op     = DP_INTERP;
                state_next = S_IG_RD0;
            end
            S_IG_RD0: begin
                cmd.op     = DP_IG_RD0;
                state_next = S_IG_FIRST;
            end
            S_IG_FIRST: begin
                cmd.op     = DP_IG_FIRST;
                state_next = S_IG_RD;
            end
            S_IG_RD: begin
                if (stat.k_more) begin
                    cmd.op     = DP_IG_RD;
                    state_next = S_IG_MUL;
                end else begin
                    state_next = S_PART_MUL;
                end
            end
            S_IG_MUL: begin
                cmd.op     = DP_IG_MUL;
                state_next = S_IG_ACC;
            end
            S_IG_ACC: begin
                cmd.op     = DP_IG_ACC;
                state_next = S_IG_RD;
            end
            S_PART_MUL: begin
                cmd.op     = DP_PART_MUL;
                state_next = S_PART_ACC;
            end
            S_PART_ACC: begin
                cmd.op     = DP_PART_ACC;
                code_next  = ST_OK;
                keep_next  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.op     = DP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result is only handed over when the output register can take it
    a_result_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_RESULT |-> stat.out_free)
        else $error("result issued while output register busy");

    // a computed value is only kept for a query that ran to the end
    a_keep_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && keep_reg) |-> code_reg == ST_OK)
        else $error("kept value with error code");

    // every accepted item leaves idle
    a_accept_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != S_IDLE)
        else $error("accepted item lost");

endmodule

### hw/rtl/tlii_dp.sv
// ----------------------------------------------------------------------------
// tlii_dp
// Datapath: point store, bisection indices, shared multiplier, restoring
// divider, trapezoid accumulator and output register.
// ----------------------------------------------------------------------------
module tlii_dp
    import tlii_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    input  tlii_in_t         s_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output logic             m_valid,
    input  logic             m_ready,
    output tlii_out_t        m_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic signed [ACC_W-1:0] ACC_HI =
        {{(ACC_W - INTEG_W + 1){1'b0}}, {(INTEG_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_LO =
        {{(ACC_W - INTEG_W + 1){1'b1}}, {(INTEG_W - 1){1'b0}}};
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (TERM_SHIFT - 1);

    logic [CFG_W-1:0] cfg_reg;
    logic [CNT_W-1:0] n_val;
    logic [IDX_W-1:0] last_idx;

    logic signed [31:0] z_reg, xlo_reg, x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [31:0] xa_reg, ya_reg, interp_reg;
    logic [IDX_W-1:0]   i_reg, j_reg, k_reg, mid;
    logic [IDX_W:0]     ij_sum;
    logic [PROD_W-1:0]  prod_reg, num_reg;
    logic               neg_reg;
    logic [31:0]        rem_reg;
    logic [DIVCNT_W-1:0] cnt_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_sat;
    logic               m_valid_reg;
    tlii_out_t          m_data_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic signed [31:0] rx, ry;

    logic [32:0]        dx, dz, mdy, ms, md;
    logic signed [32:0] dy, s_sum, d_dif;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  term_mag;
    logic signed [ACC_W-1:0] term;
    logic [32:0]        trial;
    logic               ge;
    logic signed [33:0] interp_wide;

    assign n_val = (32'(cfg_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(cfg_reg);
    assign last_idx = IDX_W'(n_val - CNT_W'(1));
    assign ij_sum = {1'b0, i_reg} + {1'b0, j_reg};
    assign mid = IDX_W'(ij_sum >> 1);

    assign ram_we = (cmd.op == DP_ACCEPT) && (s_data.op == OP_LOAD)
                    && (32'(s_data.point_index) < MAX_POINTS);
    assign ram_waddr = IDX_W'(s_data.point_index);

    always_comb begin
        unique case (cmd.op)
            DP_RD_LAST: ram_raddr = last_idx;
            DP_BIS_RD:  ram_raddr = mid;
            DP_SEG_RD0: ram_raddr = i_reg;
            DP_SEG_RD1: ram_raddr = i_reg + IDX_W'(1);
            DP_IG_RD:   ram_raddr = k_reg;
            default:    ram_raddr = '0;
        endcase
    end

    tlii_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_x_ram (
        .aclk (aclk), .we (ram_we), .waddr (ram_waddr), .wdata (s_data.point_x),
        .raddr (ram_raddr), .rdata (rx)
    );

    tlii_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_y_ram (
        .aclk (aclk), .we (ram_we), .waddr (ram_waddr), .wdata (s_data.point_y),
        .raddr (ram_raddr), .rdata (ry)
    );

    // segment geometry
    assign dx  = 33'(x1_reg) - 33'(x0_reg);
    assign dz  = 33'(z_reg) - 33'(x0_reg);
    assign dy  = 33'(y1_reg) - 33'(y0_reg);
    assign mdy = dy[32] ? 33'(-dy) : 33'(dy);

    // operands of a trapezoid term
    always_comb begin
        if (cmd.op == DP_PART_MUL) begin
            s_sum = 33'(y0_reg) + 33'(interp_reg);
            d_dif = 33'(z_reg) - 33'(x0_reg);
        end else begin
            s_sum = 33'(ya_reg) + 33'(ry);
            d_dif = 33'(rx) - 33'(xa_reg);
        end
        ms = s_sum[32] ? 33'(-s_sum) : 33'(s_sum);
        md = d_dif[32] ? 33'(-d_dif) : 33'(d_dif);
    end

    always_comb begin
        if (cmd.op == DP_SLOPE_MUL) begin
            mul_a = mdy;
            mul_b = dz;
        end else begin
            mul_a = ms;
            mul_b = md;
        end
    end

    assign term_mag = (prod_reg + ROUND_HALF) >> TERM_SHIFT;
    assign term = neg_reg ? -ACC_W'(term_mag) : ACC_W'(term_mag);

    // one restoring step per cycle, quotient shifts into the numerator
    assign trial = {rem_reg, num_reg[PROD_W-1]};
    assign ge    = trial >= dx;

    assign interp_wide = dy[32] ? (34'(y0_reg) - 34'(num_reg[32:0]))
                                : (34'(y0_reg) + 34'(num_reg[32:0]));

    assign acc_sat = (acc_reg > ACC_HI) ? ACC_HI : ((acc_reg < ACC_LO) ? ACC_LO : acc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= CFG_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.op == DP_RESULT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op) inside
            DP_ACCEPT:   z_reg <= s_data.query_z;
            DP_RD_LAST:  xlo_reg <= rx;
            DP_RANGE: begin
                i_reg <= '0;
                j_reg <= last_idx;
            end
            DP_BIS_UPD: begin
                if (z_reg > rx) begin
                    i_reg <= mid;
                end else begin
                    j_reg <= mid;
                end
            end
            DP_SEG_RD1: begin
                x0_reg <= rx;
                y0_reg <= ry;
            end
            DP_SEG_LAT: begin
                x1_reg <= rx;
                y1_reg <= ry;
            end
            DP_SLOPE_MUL: prod_reg <= mul_a * mul_b;
            DP_DIV_INIT: begin
                num_reg <= prod_reg + PROD_W'(dx[32:1]);
                rem_reg <= '0;
                cnt_reg <= DIVCNT_W'(DIV_STEPS);
            end
            DP_DIV_STEP: begin
                rem_reg <= ge ? 32'(trial - dx) : trial[31:0];
                num_reg <= {num_reg[PROD_W-2:0], ge};
                cnt_reg <= cnt_reg - DIVCNT_W'(1);
            end
            DP_INTERP:   interp_reg <= interp_wide[31:0];
            DP_IG_FIRST: begin
                xa_reg  <= rx;
                ya_reg  <= ry;
                k_reg   <= IDX_W'(1);
                acc_reg <= '0;
            end
            DP_IG_MUL, DP_PART_MUL: begin
                prod_reg <= mul_a * mul_b;
                neg_reg  <= s_sum[32] ^ d_dif[32];
                if (cmd.op == DP_IG_MUL) begin
                    xa_reg <= rx;
                    ya_reg <= ry;
                end
            end
            DP_IG_ACC: begin
                acc_reg <= acc_reg + term;
                k_reg   <= k_reg + IDX_W'(1);
            end
            DP_PART_ACC: acc_reg <= acc_reg + term;
            DP_RESULT: begin
                if (cmd.keep) begin
                    m_data_reg.interp_value   <= interp_reg;
                    m_data_reg.integral_value <= acc_sat[INTEG_W-1:0];
                    m_data_reg.status         <= (acc_sat != acc_reg) ? ST_SAT : ST_OK;
                end else begin
                    m_data_reg.interp_value   <= '0;
                    m_data_reg.integral_value <= '0;
                    m_data_reg.status         <= cmd.code;
                end
            end
            default: ;
        endcase
    end

    assign stat.n_small   = n_val < CNT_W'(2);
    assign stat.out_range = (z_reg < xlo_reg) || (z_reg > rx);
    assign stat.bis_done  = (j_reg - i_reg) <= IDX_W'(1);
    assign stat.bad_x     = rx <= x0_reg;
    assign stat.div_last  = cnt_reg == DIVCNT_W'(1);
    assign stat.k_more    = k_reg <= i_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // bisection keeps the bracket strictly ordered
    a_bis_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_BIS_UPD |=> i_reg < j_reg)
        else $error("bisection bracket collapsed");

    // the divider never runs on an empty interval
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == DP_DIV_STEP |-> dx != '0)
        else $error("division by zero width interval");

    // a new word only appears through a result command
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.op == DP_RESULT))
        else $error("output valid without result");

endmodule

### tb/table_linear_interp_integ_top_tb.sv
// ----------------------------------------------------------------------------
// table_linear_interp_integ_top_tb
// Self-checking bench for the table interpolator with trapezoid integral.
// A short table of directed words (edge values, error codes) is
// followed by random table reloads and queries under several point counts,
// with random idling on both channels, checked against a local model or an expected code.
// ----------------------------------------------------------------------------
module table_linear_interp_integ_top_tb;
    import tlii_pkg::*;

    localparam int  N_SLOTS    = 16;
    localparam int  WORDS_GOAL = 1500;
    localparam int  TAIL_FROM  = 1300;
    localparam int  WDOG_LIMIT = 50000;
    localparam int  DRAIN_WAIT = 200;
    localparam logic signed [127:0] INTEG_HI = (128'sd1 <<< 47) - 1;
    localparam logic signed [127:0] INTEG_LO = -(128'sd1 <<< 47);
    localparam logic signed [31:0]  S32_MAX  = 32'sh7fffffff;
    localparam logic signed [31:0]  S32_MIN  = 32'sh80000000;

    typedef struct {
        logic               op;
        logic [3:0]         idx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] qz;
        bit                 typed;
        status_t            st;
    } dir_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    tlii_in_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    tlii_out_t        m_data;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    logic signed [31:0] x_tab [N_SLOTS];
    logic signed [31:0] y_tab [N_SLOTS];
    int unsigned        pts_cfg = 2;
    tlii_out_t          result_q [$];
    int                 mismatches = 0;
    int                 words_sent = 0;
    int                 wdog = 0;
    bit                 tail = 1'b0;

    table_linear_interp_integ_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // round(s * d / 2^17), half away from zero
    function automatic logic signed [127:0] trap_area(logic signed [127:0] s,
                                                       logic signed [127:0] d);
        logic        neg;
        logic [127:0] ms, md, r;
        neg = (s < 0) != (d < 0);
        ms  = (s < 0) ? -s : s;
        md  = (d < 0) ? -d : d;
        r   = (ms * md + 128'd65536) >> TERM_SHIFT;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic tlii_out_t interp_integrate(tlii_in_t w);
        tlii_out_t           o;
        int unsigned         n, lo, hi, mid;
        logic signed [127:0] z, x0, x1, y0, y1, dy, ival, acc;
        logic [127:0]        mdy, dx, dz, q;
        o = '0;
        if (w.op == OP_LOAD) begin
            x_tab[w.point_index] = w.point_x;
            y_tab[w.point_index] = w.point_y;
            return o;
        end
        n = (pts_cfg > N_SLOTS) ? N_SLOTS : pts_cfg;
        if (n < 2) begin
            o.status = ST_FEW;
            return o;
        end
        z = w.query_z;
        if (w.query_z < x_tab[0] || w.query_z > x_tab[n-1]) begin
            o.status = ST_RANGE;
            return o;
        end
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (w.query_z > x_tab[mid]) lo = mid; else hi = mid;
        end
        x0 = x_tab[lo];
        x1 = x_tab[lo+1];
        y0 = y_tab[lo];
        y1 = y_tab[lo+1];
        if (x1 <= x0) begin
            o.status = ST_NONINC;
            return o;
        end
        dx   = x1 - x0;
        dz   = z - x0;
        dy   = y1 - y0;
        mdy  = (dy < 0) ? -dy : dy;
        q    = (mdy * dz + dx / 2) / dx;
        ival = (dy < 0) ? y0 - $signed(q) : y0 + $signed(q);
        acc  = 0;
        for (int k = 1; k <= lo; k++) begin
            acc += trap_area(128'(y_tab[k-1]) + 128'(y_tab[k]),
                             128'(x_tab[k]) - 128'(x_tab[k-1]));
        end
        acc += trap_area(y0 + ival, z - x0);
        o.status = ST_OK;
        if (acc > INTEG_HI) begin
            acc = INTEG_HI;
            o.status = ST_SAT;
        end
        if (acc < INTEG_LO) begin
            acc = INTEG_LO;
            o.status = ST_SAT;
        end
        o.interp_value   = ival[31:0];
        o.integral_value = acc[47:0];
        return o;
    endfunction

    // called at a falling edge; returns at a falling edge with valid possibly still high
    task automatic send_word(tlii_in_t w, bit typed, status_t st, bit quiet);
        tlii_out_t pred;
        s_data  = w;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = interp_integrate(w);
        if (typed) begin
            pred = '0;
            pred.status = st;
        end
        result_q.push_back(pred);
        words_sent++;
        if (words_sent >= TAIL_FROM) tail = 1'b1;
        @(negedge aclk);
        if (!tail && !quiet && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
    endtask

    task automatic set_points(int unsigned v);
        s_valid = 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        cfg_wr_data = CFG_W'(v);
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        pts_cfg     = v & 31;
    endtask

    function automatic tlii_in_t rand_word(logic op);
        tlii_in_t w;
        w.op          = op;
        w.point_index = 4'($urandom);
        w.point_x     = $urandom;
        w.point_y     = $urandom;
        w.query_z     = $urandom;
        return w;
    endfunction

    task automatic run_sequence();
        logic signed [31:0] xs [N_SLOTS];
        longint             base, step, zl;
        int unsigned        mode, n, nq, k;
        bit                 quiet;
        tlii_in_t           w;
        mode  = $urandom_range(0, 3);
        quiet = ($urandom_range(0, 3) == 0);
        base  = longint'($signed(32'($urandom))) >>> 1;
        for (int s = 0; s < N_SLOTS; s++) begin
            if (mode == 0)
                xs[s] = 32'(-64'sd2147483648 + longint'(s) * (64'sd1 << 28)
                            + longint'($urandom_range(0, (1 << 28) - 1)));
            else begin
                step  = $urandom_range(1, (mode == 1) ? 16 : 65536);
                base  = base + step;
                xs[s] = 32'(base);
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(1, N_SLOTS - 1);
            xs[k] = xs[k-1];
        end
        for (int s = 0; s < N_SLOTS; s++) begin
            w = rand_word(OP_LOAD);
            w.point_index = 4'(s);
            w.point_x     = xs[s];
            if (mode == 3)
                w.point_y = $urandom_range(0, 1) ? S32_MAX : S32_MIN;
            send_word(w, 1'b0, ST_OK, quiet);
        end
        n  = (pts_cfg > N_SLOTS) ? N_SLOTS : pts_cfg;
        nq = $urandom_range(8, 16);
        for (int q = 0; q < nq; q++) begin
            w = rand_word(OP_QUERY);
            if (n >= 2) begin
                case ($urandom_range(0, 9))
                    0: ;
                    1: w.query_z = xs[$urandom_range(0, n - 1)];
                    2: begin
                        zl = longint'(xs[n-1]) + 1;
                        if (zl <= 64'sd2147483647) w.query_z = 32'(zl);
                    end
                    3: w.query_z = xs[0];
                    default: begin
                        zl = longint'(xs[0]) + longint'($urandom) %
                             (longint'(xs[n-1]) - longint'(xs[0]) + 1);
                        w.query_z = 32'(zl);
                    end
                endcase
            end
            send_word(w, 1'b0, ST_OK, quiet);
            // noise: stray loads can break the ordering of x
            if ($urandom_range(0, 19) == 0)
                send_word(rand_word(OP_LOAD), 1'b0, ST_OK, quiet);
        end
    endtask

    dir_row_t directed [] = '{
        '{OP_LOAD,  4'd0, S32_MIN, S32_MAX, 32'sd0,   1'b1, ST_OK},
        '{OP_LOAD,  4'd1, S32_MAX, S32_MAX, 32'sd0,   1'b1, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  S32_MAX,  1'b0, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  S32_MIN,  1'b0, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  32'sd0,   1'b0, ST_OK},
        '{OP_LOAD,  4'd0, 32'sd0,  S32_MIN, 32'sd0,   1'b1, ST_OK},
        '{OP_LOAD,  4'd1, 32'sh10000, S32_MAX, -32'sd1, 1'b1, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  32'sh8000,  1'b0, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  32'sh10001, 1'b1, ST_RANGE},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  -32'sd1,    1'b1, ST_RANGE},
        '{OP_LOAD,  4'd1, 32'sd0,  32'sd5,  32'sd0,   1'b1, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  32'sd0,   1'b1, ST_NONINC},
        '{OP_LOAD,  4'd0, S32_MIN, S32_MIN, 32'sd0,   1'b1, ST_OK},
        '{OP_LOAD,  4'd1, S32_MAX, S32_MIN, 32'sd0,   1'b1, ST_OK},
        '{OP_QUERY, 4'd15, S32_MAX, S32_MIN, S32_MAX, 1'b0, ST_OK},
        '{OP_QUERY, 4'd0, 32'sd0,  32'sd0,  32'sd12345, 1'b0, ST_OK}
    };

    int unsigned pts_plan [] = '{16, 0, 1, 3, 31, 17, 8, 2, 16};

    initial begin
        tlii_in_t w;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        foreach (directed[r]) begin
            w.op          = directed[r].op;
            w.point_index = directed[r].idx;
            w.point_x     = directed[r].px;
            w.point_y     = directed[r].py;
            w.query_z     = directed[r].qz;
            send_word(w, directed[r].typed, directed[r].st, 1'b0);
        end
        set_points(0);
        send_word(rand_word(OP_QUERY), 1'b1, ST_FEW, 1'b0);
        foreach (pts_plan[p]) begin
            set_points(pts_plan[p]);
            if (p == 4) set_points($urandom_range(0, 31));
            while (words_sent < (p + 1) * WORDS_GOAL / pts_plan.size())
                run_sequence();
        end
        s_valid = 1'b0;
        while (result_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side back-pressure in bursts
    initial begin
        int unsigned hold;
        @(negedge aclk);
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!tail && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                hold = $urandom_range(1, 14);
                repeat (hold - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        tlii_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: interp %h integ %h status %0d",
                             m_data.interp_value, m_data.integral_value, m_data.status);
            end else begin
                want = result_q.pop_front();
                if (m_data.interp_value !== want.interp_value ||
                    m_data.integral_value !== want.integral_value ||
                    m_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%h/%0d got %h/%h/%0d",
                                 want.interp_value, want.integral_value, want.status,
                                 m_data.interp_value, m_data.integral_value,
                                 m_data.status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
